[hw/rtl/vtpg_pkg.sv]
// ----------------------------------------------------------------------------
// vtpg_pkg - shared types and constants for the test pattern generator
// Field widths, register and mode codes, palette and divide constants.
// ----------------------------------------------------------------------------
package vtpg_pkg;

	localparam int COL_W      = 12;
	localparam int PIX_W      = 10;
	localparam int LINE_W     = 10;
	localparam int FRAME_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int MODE_W     = 3;
	localparam int SHIFT_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_MODE  = 3'd0,
		REG_FIRST_VISIBLE = 3'd1,
		REG_LAST_VISIBLE  = 3'd2,
		REG_SHIFT_BASE    = 3'd3
	} cfg_reg_t;

	// pattern select
	typedef enum logic [MODE_W-1:0] {
		MODE_HSTRIPE = 3'd0,
		MODE_VSTRIPE = 3'd1,
		MODE_BARS    = 3'd2,
		MODE_CHECKER = 3'd3,
		MODE_DIAG    = 3'd4,
		MODE_MOSAIC  = 3'd5
	} mode_t;

	// reset values
	localparam logic [COL_W-1:0]   FIRST_VIS_RST  = 12'd600;
	localparam logic [COL_W-1:0]   LAST_VIS_RST   = 12'd3900;
	localparam logic [SHIFT_W-1:0] SHIFT_BASE_RST = 5'd10;

	// extra shift of the animated modes, and the saturation point
	localparam int SH_BIAS_DIAG   = 5;
	localparam int SH_BIAS_MOSAIC = 14;
	localparam int SHIFT_MAX      = 31;

	// line/40 and line/24 by rounded-up reciprocals, exact for 10-bit lines
	localparam int DIVM_W = 11;
	localparam logic [DIVM_W-1:0] DIV40_MUL = 11'd1639;
	localparam int                DIV40_SH  = 16;
	localparam logic [DIVM_W-1:0] DIV24_MUL = 11'd1366;
	localparam int                DIV24_SH  = 15;

	localparam logic [COLOR_W-1:0] COLOR_ON = 8'hFF;

	function automatic logic [COLOR_W-1:0] palette(input logic [2:0] idx);
		logic [COLOR_W-1:0] c;
		case (idx)
			3'd0:    c = 8'h00;
			3'd1:    c = 8'h07;
			3'd2:    c = 8'h3F;
			3'd3:    c = 8'h38;
			3'd4:    c = 8'hF8;
			3'd5:    c = 8'h0F;
			3'd6:    c = 8'hC0;
			default: c = 8'hFF;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/vga_test_pattern_generator.sv]
// ----------------------------------------------------------------------------
// vga_test_pattern_generator - per-pixel test pattern colour pipeline
// Stripes, colour bars, checkerboard and two animated patterns, one pixel a beat.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one beat per pixel (column_count, pixel_index, line_number,
//                 frame_number), in_valid / in_ready.
//   out channel : one beat per input beat (pixel_color, visible), same order,
//                 out_valid / out_ready.
//   cfg channel : cfg_index / cfg_data write, cfg_ready always high. Write only
//                 while the pipeline is empty. Unknown indexes are ignored.
//   Throughput is one pixel per cycle while out_ready stays high. Three
//   stages: operand products, the shared 16x32 animation multiplier,
//   then the arithmetic shift and colour select.
//   Each stage holds a valid bit and takes a new beat when it is empty or
//   its successor takes its beat, so a stalled receiver only freezes the
//   stages behind the held result; bubbles in front of it keep filling.
//   Reset empties the pipeline and restores the register defaults (mode 0,
//   visible window 600..3900, shift base 10).
// ----------------------------------------------------------------------------
module vga_test_pattern_generator
	import vtpg_pkg::*;
#(
	parameter int LINE_PIXELS = 800,
	parameter int BAR_COUNT   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// pixel position in
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COL_W-1:0]      column_count,
	input  logic [PIX_W-1:0]      pixel_index,
	input  logic [LINE_W-1:0]     line_number,
	input  logic [FRAME_W-1:0]    frame_number,
	// colour out
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  visible
);

	// Bar width and its reciprocal. A rounded-up reciprocal with a 20-bit
	// shift gives the exact quotient for every 10-bit index and width.
	localparam int BAR_W    = LINE_PIXELS / BAR_COUNT;
	localparam int BAR_DIV  = (BAR_W == 0) ? 1 : BAR_W;
	localparam int RECIP_SH = 20;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int BPROD_W  = PIX_W + RECIP_W;
	localparam logic [RECIP_W-1:0] BAR_RECIP =
		RECIP_W'(((1 << RECIP_SH) + BAR_DIV - 1) / BAR_DIV);
	localparam logic [PIX_W:0] BAR_END  = (PIX_W + 1)'(BAR_W * BAR_COUNT);
	localparam logic [PIX_W:0] LINE_END = (PIX_W + 1)'(LINE_PIXELS);
	localparam logic           BAR_NONE = (BAR_W == 0);

	localparam int HCOL_W  = COL_W - 1;
	localparam int LPROD_W = LINE_W + DIVM_W;
	localparam int MOS_W   = HCOL_W + LINE_W;
	localparam int TERM_W  = HCOL_W + 1;
	localparam int PROD_W  = 32;
	localparam int SUM_W   = SHIFT_W + 1;

	// ---------------- configuration registers ----------------
	mode_t               mode_q;
	logic [COL_W-1:0]    first_vis_q;
	logic [COL_W-1:0]    last_vis_q;
	logic [SHIFT_W-1:0]  shift_base_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_HSTRIPE;
			first_vis_q  <= FIRST_VIS_RST;
			last_vis_q   <= LAST_VIS_RST;
			shift_base_q <= SHIFT_BASE_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_MODE:  mode_q       <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_FIRST_VISIBLE: first_vis_q  <= cfg_data[COL_W-1:0];
				REG_LAST_VISIBLE:  last_vis_q   <= cfg_data[COL_W-1:0];
				REG_SHIFT_BASE:    shift_base_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage handshake ----------------
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: window test and operand products ----------------
	logic [HCOL_W-1:0]  col_half;
	logic               vis_c;
	logic [BPROD_W-1:0] bar_prod;
	logic [LPROD_W-1:0] div40_prod;
	logic [LPROD_W-1:0] div24_prod;
	logic [MOS_W-1:0]   mos_c;
	logic [HCOL_W-1:0]  diag_x;
	logic [SUM_W-1:0]   sh_sum;
	logic [SHIFT_W-1:0] shamt_c;
	logic               bar_out_c;

	assign col_half = column_count[COL_W-1:1];
	assign vis_c    = (column_count >= first_vis_q) && (column_count < last_vis_q)
	                  && (mode_q <= MODE_MOSAIC);

	assign bar_prod   = BPROD_W'(pixel_index) * BPROD_W'(BAR_RECIP);
	assign div40_prod = LPROD_W'(line_number) * LPROD_W'(DIV40_MUL);
	assign div24_prod = LPROD_W'(line_number) * LPROD_W'(DIV24_MUL);
	assign mos_c      = MOS_W'(col_half) * MOS_W'(line_number);
	assign diag_x     = col_half ^ HCOL_W'(line_number);
	assign bar_out_c  = BAR_NONE || ({1'b0, pixel_index} >= BAR_END)
	                    || ({1'b0, pixel_index} >= LINE_END);

	// shift amount saturates at 31: only the sign survives
	assign sh_sum  = (mode_q == MODE_MOSAIC) ? SUM_W'(shift_base_q) + SUM_W'(SH_BIAS_MOSAIC)
	                                         : SUM_W'(shift_base_q) + SUM_W'(SH_BIAS_DIAG);
	assign shamt_c = (sh_sum > SUM_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : sh_sum[SHIFT_W-1:0];

	logic               vis_s1;
	mode_t              mode_s1;
	logic [SHIFT_W-1:0] shamt_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic [TERM_W-1:0]  term4_s1;   // ~((col/2) ^ line) as a signed 12-bit value
	logic [MOS_W-1:0]   mos_s1;
	logic [2:0]         hstripe_s1;
	logic [2:0]         vstripe_s1;
	logic [1:0]         bar_s1;
	logic               bar_out_s1;
	logic [1:0]         band_s1;
	logic               chk_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			vis_s1     <= vis_c;
			mode_s1    <= mode_q;
			shamt_s1   <= shamt_c;
			frame_s1   <= frame_number;
			term4_s1   <= {1'b1, ~diag_x};
			mos_s1     <= mos_c;
			hstripe_s1 <= line_number[8:6];
			vstripe_s1 <= column_count[10:8];
			bar_s1     <= bar_prod[RECIP_SH+1:RECIP_SH];
			bar_out_s1 <= bar_out_c;
			band_s1    <= div40_prod[DIV40_SH+1:DIV40_SH];
			chk_s1     <= div24_prod[DIV24_SH] ^ column_count[2];
		end
	end

	// ---------------- stage 2: static colours, animation product ----------------
	logic [COLOR_W-1:0] color_a_c;
	logic [PROD_W-1:0]  mul_b;
	logic [PROD_W-1:0]  prod_c;

	always_comb begin
		case (mode_s1)
			MODE_HSTRIPE: color_a_c = palette(hstripe_s1);
			MODE_VSTRIPE: color_a_c = palette(vstripe_s1);
			MODE_BARS:    color_a_c = bar_out_s1 ? '0
			                          : palette({bar_s1, 1'b0} + 3'd1 + {1'b0, band_s1});
			MODE_CHECKER: color_a_c = chk_s1 ? COLOR_ON : '0;
			default:      color_a_c = '0;
		endcase
	end

	// one multiplier for both animated modes; mod 2^32 wrap falls out of the width
	assign mul_b  = (mode_s1 == MODE_DIAG)
	                ? {{(PROD_W - TERM_W){term4_s1[TERM_W-1]}}, term4_s1}
	                : PROD_W'(mos_s1);
	assign prod_c = PROD_W'(frame_s1) * mul_b;

	logic               vis_s2;
	logic               use_prod_s2;
	logic [SHIFT_W-1:0] shamt_s2;
	logic [COLOR_W-1:0] color_a_s2;
	logic [PROD_W-1:0]  prod_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			vis_s2      <= vis_s1;
			use_prod_s2 <= (mode_s1 == MODE_DIAG) || (mode_s1 == MODE_MOSAIC);
			shamt_s2    <= shamt_s1;
			color_a_s2  <= color_a_c;
			prod_s2     <= prod_c;
		end
	end

	// ---------------- stage 3: arithmetic shift, blanking, output ----------------
	logic signed [PROD_W-1:0] shifted;
	logic [COLOR_W-1:0]       color_c;

	assign shifted = $signed(prod_s2) >>> shamt_s2;
	assign color_c = !vis_s2     ? '0
	               : use_prod_s2 ? shifted[COLOR_W-1:0]
	               : color_a_s2;

	logic [COLOR_W-1:0] color_s3;
	logic               visible_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			color_s3   <= color_c;
			visible_s3 <= vis_s2;
		end
	end

	assign out_valid   = v_s3;
	assign pixel_color = color_s3;
	assign visible     = visible_s3;

endmodule

[hw/rtl/vtpg_checker.sv]
// ----------------------------------------------------------------------------
// vtpg_checker - port-level assertions for the test pattern generator
// Bound to the top level; watches the pixel and colour channels only.
// ----------------------------------------------------------------------------
module vtpg_checker
	import vtpg_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COLOR_W-1:0]    pixel_color,
	input logic                  visible
);

	// a held beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_color) && $stable(visible))
		else $error("output beat changed while stalled");

	// blanked pixels carry black
	a_blank_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> pixel_color == '0)
		else $error("blanked pixel with nonzero colour");

	// with the receiver ready while it moves through the stages, an accepted beat reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("pixel beat did not emerge after three cycles");

	// an empty output stage always frees the input side
	a_no_deadlock: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(!out_valid) && $past(!out_valid, 2) |-> in_ready)
		else $error("input stalled with empty pipeline");

endmodule

bind vga_test_pattern_generator vtpg_checker u_vtpg_checker (.*);

[sim/vga_test_pattern_generator_test.sv]
// ----------------------------------------------------------------------------
// vga_test_pattern_generator_test - self-checking bench for the pattern pipe
// Drives pixel positions through the in channel under random gaps and output
// stalls, predicts colour and visible flag per beat, and compares in order.
// ----------------------------------------------------------------------------
module vga_test_pattern_generator_test;
	import vtpg_pkg::*;

	// block parameters, passed down so the predictor and the DUT agree
	localparam int PIXELS_PER_LINE = 800;
	localparam int BARS            = 12;

	// pattern geometry
	localparam int HSTRIPE_LINES = 64;
	localparam int VSTRIPE_COLS  = 256;
	localparam int BAR_LINES     = 40;
	localparam int CHECK_LINES   = 24;
	localparam int CHECK_COLS    = 4;
	localparam int DIAG_BIAS     = 5;
	localparam int MOSAIC_BIAS   = 14;
	localparam int SHIFT_CAP     = 31;

	localparam logic [COLOR_W-1:0] STRIPE_COLORS [8] =
		'{8'h00, 8'h07, 8'h3F, 8'h38, 8'hF8, 8'h0F, 8'hC0, 8'hFF};

	// mode codes past the last pattern, and register indexes past the map
	localparam logic [MODE_W-1:0]    MODE_UNUSED_A = 3'd6;
	localparam logic [MODE_W-1:0]    MODE_UNUSED_B = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	// run shape
	localparam int SEGMENTS     = 10;
	localparam int SEG_PIXELS   = 55;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic [PIX_W-1:0]   px;
		logic [LINE_W-1:0]  line;
		logic [FRAME_W-1:0] frame;
	} position_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               vis;
	} pixel_out_t;

	// Predicts one pixel per accepted position and checks output beats in order.
	class pattern_board;
		logic [MODE_W-1:0]  mode;
		logic [COL_W-1:0]   first_vis;
		logic [COL_W-1:0]   last_vis;
		logic [SHIFT_W-1:0] shift_base;
		pixel_out_t         expected_pixels[$];
		int unsigned        fails;

		function new();
			mode       = MODE_HSTRIPE;
			first_vis  = 12'd600;
			last_vis   = 12'd3900;
			shift_base = 5'd10;
			fails      = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PATTERN_MODE:  mode       = data[MODE_W-1:0];
				REG_FIRST_VISIBLE: first_vis  = data[COL_W-1:0];
				REG_LAST_VISIBLE:  last_vis   = data[COL_W-1:0];
				REG_SHIFT_BASE:    shift_base = data[SHIFT_W-1:0];
				default: ;
			endcase
		endfunction

		function pixel_out_t predict_color(input position_t p);
			pixel_out_t  r;
			logic [31:0] term;
			logic [31:0] prod;
			int unsigned sh;
			int unsigned bar_w;
			r     = '0;
			r.vis = (p.col >= first_vis) && (p.col < last_vis) && (mode <= MODE_MOSAIC);
			if (!r.vis)
				return r;
			case (mode)
				MODE_HSTRIPE: r.color = STRIPE_COLORS[(p.line / HSTRIPE_LINES) % 8];
				MODE_VSTRIPE: r.color = STRIPE_COLORS[(p.col / VSTRIPE_COLS) % 8];
				MODE_BARS: begin
					bar_w = PIXELS_PER_LINE / BARS;
					if (bar_w == 0 || p.px >= PIXELS_PER_LINE || p.px >= bar_w * BARS)
						r.color = '0;
					else
						r.color = STRIPE_COLORS[(2 * (p.px / bar_w) + 1
							+ ((p.line / BAR_LINES) % 4)) % 8];
				end
				MODE_CHECKER:
					r.color = (((p.line / CHECK_LINES) ^ (p.col / CHECK_COLS)) & 1)
						? 8'hFF : 8'h00;
				MODE_DIAG: begin
					term = ~(32'(p.col / 2) ^ 32'(p.line));
					prod = 32'(p.frame) * term;
					sh   = shift_base + DIAG_BIAS;
					if (sh > SHIFT_CAP)
						sh = SHIFT_CAP;
					r.color = 8'($signed(prod) >>> sh);
				end
				MODE_MOSAIC: begin
					term = 32'(p.col / 2) * 32'(p.line);
					prod = 32'(p.frame) * term;
					sh   = shift_base + MOSAIC_BIAS;
					if (sh > SHIFT_CAP)
						sh = SHIFT_CAP;
					r.color = 8'($signed(prod) >>> sh);
				end
				default: r.color = '0;
			endcase
			return r;
		endfunction

		function void take_position(input position_t p);
			expected_pixels.push_back(predict_color(p));
		endfunction

		function void check_color(input logic [COLOR_W-1:0] color, input logic vis);
			pixel_out_t want;
			if (expected_pixels.size() == 0) begin
				$error("output beat with no pixel outstanding: pixel_color %02h visible %0b",
					color, vis);
				fails++;
				return;
			end
			want = expected_pixels.pop_front();
			if (color !== want.color) begin
				$error("pixel_color expected %02h actual %02h", want.color, color);
				fails++;
			end
			if (vis !== want.vis) begin
				$error("visible expected %0b actual %0b", want.vis, vis);
				fails++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [COL_W-1:0]      column_count;
	logic [PIX_W-1:0]      pixel_index;
	logic [LINE_W-1:0]     line_number;
	logic [FRAME_W-1:0]    frame_number;
	logic                  out_valid;
	logic                  out_ready;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  visible;

	pattern_board board = new();

	// idle rates in percent, and the long receiver hold-off request
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_request;

	vga_test_pattern_generator #(
		.LINE_PIXELS(PIXELS_PER_LINE),
		.BAR_COUNT  (BARS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.column_count(column_count),
		.pixel_index (pixel_index),
		.line_number (line_number),
		.frame_number(frame_number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_color (pixel_color),
		.visible     (visible)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Both handshakes are sampled right after the edge, where every signal
	// still holds the value it had at the edge. Input beat is noted first so a
	// combinational input-to-output path would still find its expectation.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			board.take_position('{column_count, pixel_index, line_number, frame_number});
		if (out_valid && out_ready)
			board.check_color(pixel_color, visible);
	end

	// Receiver: random stalls, plus one long hold-off on request so the
	// pipeline fills and back-pressures the input.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one pixel beat and hold it until taken; maybe idle afterwards.
	// With no idle, in_valid stays high for the next beat.
	task automatic send_pixel(input position_t p);
		in_valid     <= 1'b1;
		column_count <= p.col;
		pixel_index  <= p.px;
		line_number  <= p.line;
		frame_number <= p.frame;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic send_at(input logic [COL_W-1:0] col, input logic [PIX_W-1:0] px,
			input logic [LINE_W-1:0] line, input logic [FRAME_W-1:0] frame);
		send_pixel('{col, px, line, frame});
	endtask

	// Stop offering and wait for every outstanding pixel; each beat makes
	// exactly one result, so an empty queue means an empty pipeline. The queue
	// is read only after in_valid has been dropped, so the last beat taken is in it.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// cfg_valid is left high between back-to-back writes; the caller drops it.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, data);
	endtask

	// Full register set, written only on an idle pipeline. Junk in the upper
	// data bits of the narrow registers must be ignored.
	task automatic config_pattern(input logic [MODE_W-1:0] mode,
			input logic [COL_W-1:0] first, input logic [COL_W-1:0] last,
			input logic [SHIFT_W-1:0] shift, input bit poke_unused);
		drain_pipeline();
		if (poke_unused)
			put_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
				CFG_DATA_W'($urandom));
		put_reg(REG_PATTERN_MODE, {9'($urandom), mode});
		put_reg(REG_FIRST_VISIBLE, first);
		put_reg(REG_LAST_VISIBLE, last);
		put_reg(REG_SHIFT_BASE, {7'($urandom), shift});
		cfg_valid <= 1'b0;
	endtask

	// Mostly inside the visible window, sometimes anywhere on the line;
	// pixel index mostly on the bars, sometimes past them.
	function automatic position_t random_position(input logic [COL_W-1:0] first,
			input logic [COL_W-1:0] last);
		position_t p;
		if ($urandom_range(3) == 0 || first >= last)
			p.col = COL_W'($urandom_range(4095));
		else
			p.col = COL_W'($urandom_range(last - 1, first));
		p.px   = PIX_W'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(799));
		p.line = LINE_W'($urandom_range(1023));
		case ($urandom_range(7))
			0:       p.frame = '0;
			1:       p.frame = '1;
			default: p.frame = FRAME_W'($urandom);
		endcase
		return p;
	endfunction

	initial begin
		logic [MODE_W-1:0]  mode;
		logic [COL_W-1:0]   first;
		logic [COL_W-1:0]   last;
		logic [SHIFT_W-1:0] shift;

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		column_count  = '0;
		pixel_index   = '0;
		line_number   = '0;
		frame_number  = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset defaults: stripes, window edges at 600 and 3900
		send_at(12'd0, 10'd0, 10'd0, 16'd0);
		send_at(12'd599, 10'd1023, 10'd1023, 16'hFFFF);
		send_at(12'd600, 10'd0, 10'd64, 16'd1);
		send_at(12'd3899, 10'd1023, 10'd1023, 16'hFFFF);
		send_at(12'd3900, 10'd0, 10'd0, 16'd0);
		send_at(12'd4095, 10'd1023, 10'd1023, 16'hFFFF);

		config_pattern(MODE_VSTRIPE, 12'd0, 12'd4095, 5'd10, 1'b0);
		send_at(12'd0, 10'd0, 10'd0, 16'd0);
		send_at(12'd4094, 10'd1023, 10'd1023, 16'hFFFF);

		// bars: last pixel of the last bar, first pixel past the bars, top index
		config_pattern(MODE_BARS, 12'd0, 12'd4095, 5'd10, 1'b0);
		send_at(12'd700, 10'd791, 10'd39, 16'd0);
		send_at(12'd700, 10'd792, 10'd40, 16'd0);
		send_at(12'd700, 10'd1023, 10'd1023, 16'd0);

		config_pattern(MODE_CHECKER, 12'd0, 12'd4095, 5'd10, 1'b0);
		send_at(12'd4, 10'd0, 10'd24, 16'd0);
		send_at(12'd4094, 10'd1023, 10'd1023, 16'hFFFF);

		// animated modes at the smallest shift and at a saturating shift;
		// frame * ~0 is negative, so the saturated sign fills the byte
		config_pattern(MODE_DIAG, 12'd0, 12'd4095, 5'd0, 1'b0);
		send_at(12'd4094, 10'd0, 10'd1023, 16'hFFFF);
		config_pattern(MODE_DIAG, 12'd0, 12'd4095, 5'd31, 1'b0);
		send_at(12'd0, 10'd0, 10'd0, 16'd1);
		config_pattern(MODE_MOSAIC, 12'd0, 12'd4095, 5'd0, 1'b0);
		send_at(12'd4094, 10'd0, 10'd1023, 16'hFFFF);
		config_pattern(MODE_MOSAIC, 12'd0, 12'd4095, 5'd31, 1'b0);
		send_at(12'd4094, 10'd0, 10'd1023, 16'hFFFF);

		// modes past the last pattern blank everything; stray register index
		config_pattern(MODE_UNUSED_A, 12'd0, 12'd4095, 5'd10, 1'b0);
		send_at(12'd1000, 10'd5, 10'd5, 16'd5);
		config_pattern(MODE_UNUSED_B, 12'd0, 12'd4095, 5'd10, 1'b1);
		send_at(12'd1000, 10'd5, 10'd5, 16'd5);

		// empty and inverted windows
		config_pattern(MODE_HSTRIPE, 12'd100, 12'd100, 5'd10, 1'b0);
		send_at(12'd100, 10'd0, 10'd100, 16'd0);
		config_pattern(MODE_HSTRIPE, 12'd200, 12'd100, 5'd10, 1'b0);
		send_at(12'd150, 10'd0, 10'd100, 16'd0);

		// --- random ---
		// phase 0: sender idles lightly, receiver heavily; phase 1 swapped;
		// phase 2 both flat out, with one long receiver hold-off at its start
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				// every mode code once, then valid patterns only
				if (seg < 8)
					mode = MODE_W'(seg);
				else
					mode = MODE_W'($urandom_range(MODE_MOSAIC, MODE_HSTRIPE));
				case (seg % 4)
					0: begin
						first = '0;
						last  = '1;
					end
					1: begin
						first = COL_W'($urandom_range(1000));
						last  = COL_W'($urandom_range(4095, 3000));
					end
					2: begin
						first = COL_W'($urandom_range(4095));
						last  = COL_W'($urandom_range(4095));
					end
					default: begin
						first = COL_W'($urandom_range(700, 300));
						last  = COL_W'($urandom_range(3999, 3500));
					end
				endcase
				case (seg)
					0:       shift = '0;
					1:       shift = '1;
					2:       shift = 5'd17;
					default: shift = SHIFT_W'($urandom_range(31));
				endcase
				config_pattern(mode, first, last, shift, $urandom_range(3) == 0);
				if (phase == 2 && seg == 0)
					hold_request = 1'b1;
				repeat (SEG_PIXELS) send_pixel(random_position(first, last));
			end
		end

		drain_pipeline();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
hw/rtl/vtpg_pkg.sv
hw/rtl/vga_test_pattern_generator.sv
hw/rtl/vtpg_checker.sv
sim/vga_test_pattern_generator_test.sv
